FILE: src/ddo_pkg.sv
`default_nettype none
package ddo_pkg;

    localparam int CordicStages = 16;
    localparam int AtanLen      = 24;
    localparam int IterW        = 5;

    localparam int HeadW  = 29;
    localparam int AngW   = 30;
    localparam int PosW   = 34;
    localparam int RotW   = 41;
    localparam int CoordW = 32;
    localparam int GainW  = 16;
    localparam int DutyW  = 7;
    localparam int DistW  = 23;
    localparam int MulAW  = 24;
    localparam int MulBW  = 32;
    localparam int MulW   = MulAW + MulBW;
    localparam int FracW  = 30;

    typedef logic signed [HeadW-1:0]  heading_t;
    typedef logic signed [AngW-1:0]   angle_t;
    typedef logic signed [PosW-1:0]   pos_t;
    typedef logic signed [RotW-1:0]   rot_t;
    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [GainW-1:0]         gain_t;
    typedef logic [DutyW-1:0]         duty_t;

    localparam angle_t Deg90      = AngW'(94371840);
    localparam angle_t Deg180     = AngW'(188743680);
    localparam angle_t Deg360     = AngW'(377487360);
    localparam angle_t DegNeg90   = -Deg90;
    localparam angle_t DegNeg180  = -Deg180;
    localparam coord_t CordicStart = CoordW'(652032874);

    localparam gain_t TurnGainReset  = GainW'(4194);
    localparam gain_t DriveGainReset = GainW'(5622);

    localparam logic [1:0] TurnNone = 2'd0;
    localparam logic [1:0] TurnCcw  = 2'd1;
    localparam logic [1:0] TurnCw   = 2'd2;

    localparam logic RegTurnGain  = 1'b0;
    localparam logic RegDriveGain = 1'b1;

    // arctangent of 2^-i in units of 2^-20 degree
    function automatic angle_t atan_entry(input logic [IterW-1:0] idx);
        angle_t v;
        case (idx)
            5'd0:    v = AngW'(47185920);
            5'd1:    v = AngW'(27855475);
            5'd2:    v = AngW'(14718068);
            5'd3:    v = AngW'(7471121);
            5'd4:    v = AngW'(3750058);
            5'd5:    v = AngW'(1876857);
            5'd6:    v = AngW'(938658);
            5'd7:    v = AngW'(469357);
            5'd8:    v = AngW'(234682);
            5'd9:    v = AngW'(117342);
            5'd10:   v = AngW'(58671);
            5'd11:   v = AngW'(29335);
            5'd12:   v = AngW'(14668);
            5'd13:   v = AngW'(7334);
            5'd14:   v = AngW'(3667);
            5'd15:   v = AngW'(1833);
            5'd16:   v = AngW'(917);
            5'd17:   v = AngW'(458);
            5'd18:   v = AngW'(229);
            5'd19:   v = AngW'(115);
            5'd20:   v = AngW'(57);
            5'd21:   v = AngW'(29);
            5'd22:   v = AngW'(14);
            5'd23:   v = AngW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/differential_drive_odometry_core.sv
// steps: turn multiply, heading update, then done; when driving, the distance multiply,
//   CORDIC iterations, flip and the x and y multiply-add come between; the iterations dominate
// throughput: one tick at a time, a new tick is taken only once back in idle
//   after the result is raised; a held result stalls the input
// reset: asynchronous, active low; heading, positions and rotation total clear
//   to zero, gains return to 4194 and 5622
`default_nettype none
module differential_drive_odometry_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire ddo_pkg::gain_t        cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  system_on,
    input  wire logic                  motor_running,
    input  wire logic [1:0]            turn_direction,
    input  wire logic                  driving_forward,
    input  wire ddo_pkg::duty_t        duty_percent,
    input  wire logic                  clear_rotation,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ddo_pkg::pos_t              pos_x,
    output ddo_pkg::pos_t              pos_y,
    output ddo_pkg::heading_t          heading,
    output ddo_pkg::rot_t              rotation_total
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TURN,
        S_HEAD,
        S_DIST,
        S_ITER,
        S_FLIP,
        S_MULX,
        S_ADDX,
        S_MULY,
        S_ADDY,
        S_DONE
    } state_t;

    state_t               state_reg;
    gain_t                turn_gain_reg;
    gain_t                drive_gain_reg;
    heading_t             heading_reg;
    pos_t                 pos_x_reg;
    pos_t                 pos_y_reg;
    rot_t                 rot_reg;
    logic                 act_reg;
    logic                 fwd_reg;
    logic [1:0]           dir_reg;
    duty_t                duty_reg;
    coord_t               cx_reg;
    coord_t               cy_reg;
    angle_t               cz_reg;
    logic                 flip_reg;
    logic [IterW-1:0]     iter_reg;
    logic [DistW-1:0]     dist_reg;
    logic signed [MulW-1:0] mul_reg;
    logic                 out_valid_reg;
    pos_t                 out_pos_x_reg;
    pos_t                 out_pos_y_reg;
    heading_t             out_heading_reg;
    rot_t                 out_rot_reg;

    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [MulW-1:0]  mul_next;
    logic signed [DistW:0]   delta;
    angle_t                  head_sum;
    heading_t                head_next;
    logic signed [RotW:0]    rot_sum;
    rot_t                    rot_next;
    angle_t                  ang;
    angle_t                  z_init;
    logic                    flip_init;
    coord_t                  x_sh;
    coord_t                  y_sh;
    coord_t                  cx_next;
    coord_t                  cy_next;
    angle_t                  cz_next;
    angle_t                  atan_val;
    pos_t                    pos_sel;
    logic signed [PosW:0]    pos_sum;
    pos_t                    pos_next;

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign pos_x          = out_pos_x_reg;
    assign pos_y          = out_pos_y_reg;
    assign heading        = out_heading_reg;
    assign rotation_total = out_rot_reg;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TURN:
            begin
                mul_a = MulAW'(duty_reg);
                mul_b = MulBW'(turn_gain_reg);
            end
            S_DIST:
            begin
                mul_a = MulAW'(duty_reg);
                mul_b = MulBW'(drive_gain_reg);
            end
            S_MULX:
            begin
                mul_a = MulAW'(dist_reg);
                mul_b = cx_reg;
            end
            S_MULY:
            begin
                mul_a = MulAW'(dist_reg);
                mul_b = cy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_next = mul_a * mul_b;
    end

    // heading and rotation update
    always_comb
    begin
        case (dir_reg)
            TurnCcw: delta = $signed({1'b0, mul_reg[DistW-1:0]});
            TurnCw:  delta = -$signed({1'b0, mul_reg[DistW-1:0]});
            default: delta = '0;
        endcase
        head_sum = AngW'(heading_reg) + AngW'(delta);
        if (head_sum > Deg180)
            head_next = HeadW'(head_sum - Deg360);
        else if (head_sum < DegNeg180)
            head_next = HeadW'(head_sum + Deg360);
        else
            head_next = HeadW'(head_sum);
        rot_sum = (RotW+1)'(rot_reg) + (RotW+1)'(delta);
        if (rot_sum[RotW] != rot_sum[RotW-1])
            rot_next = {rot_sum[RotW], {(RotW-1){~rot_sum[RotW]}}};
        else
            rot_next = rot_sum[RotW-1:0];
    end

    // cordic angle reduction and one rotation step
    always_comb
    begin
        ang = AngW'(heading_reg);
        if (ang > Deg90)
        begin
            z_init    = ang - Deg180;
            flip_init = 1'b1;
        end
        else if (ang < DegNeg90)
        begin
            z_init    = ang + Deg180;
            flip_init = 1'b1;
        end
        else
        begin
            z_init    = ang;
            flip_init = 1'b0;
        end
        atan_val = atan_entry(iter_reg);
        x_sh = cx_reg >>> iter_reg;
        y_sh = cy_reg >>> iter_reg;
        if (!cz_reg[AngW-1])
        begin
            cx_next = cx_reg - y_sh;
            cy_next = cy_reg + x_sh;
            cz_next = cz_reg - atan_val;
        end
        else
        begin
            cx_next = cx_reg + y_sh;
            cy_next = cy_reg - x_sh;
            cz_next = cz_reg + atan_val;
        end
    end

    // position accumulate, shared by both axes
    always_comb
    begin
        pos_sel = (state_reg == S_ADDX) ? pos_x_reg : pos_y_reg;
        pos_sum = (PosW+1)'(pos_sel) + (PosW+1)'(mul_reg >>> FracW);
        if (pos_sum[PosW] != pos_sum[PosW-1])
            pos_next = {pos_sum[PosW], {(PosW-1){~pos_sum[PosW]}}};
        else
            pos_next = pos_sum[PosW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            turn_gain_reg   <= TurnGainReset;
            drive_gain_reg  <= DriveGainReset;
            heading_reg     <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            rot_reg         <= '0;
            act_reg         <= 1'b0;
            fwd_reg         <= 1'b0;
            dir_reg         <= TurnNone;
            duty_reg        <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            cz_reg          <= '0;
            flip_reg        <= 1'b0;
            iter_reg        <= '0;
            dist_reg        <= '0;
            mul_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_pos_x_reg   <= '0;
            out_pos_y_reg   <= '0;
            out_heading_reg <= '0;
            out_rot_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == RegTurnGain)
                    turn_gain_reg <= cfg_data;
                else
                    drive_gain_reg <= cfg_data;
            end

            // the done step handles the output register itself
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg  <= system_on & motor_running;
                        fwd_reg  <= driving_forward;
                        dir_reg  <= turn_direction;
                        duty_reg <= duty_percent;
                        if (clear_rotation)
                            rot_reg <= '0;
                        state_reg <= S_TURN;
                    end
                end
                S_TURN:
                begin
                    mul_reg   <= mul_next;
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    if (act_reg)
                    begin
                        heading_reg <= head_next;
                        rot_reg     <= rot_next;
                    end
                    state_reg <= (act_reg && fwd_reg) ? S_DIST : S_DONE;
                end
                S_DIST:
                begin
                    mul_reg   <= mul_next;
                    cx_reg    <= CordicStart;
                    cy_reg    <= '0;
                    cz_reg    <= z_init;
                    flip_reg  <= flip_init;
                    iter_reg  <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    cx_reg   <= cx_next;
                    cy_reg   <= cy_next;
                    cz_reg   <= cz_next;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == IterW'(CordicStages - 1))
                        state_reg <= S_FLIP;
                end
                S_FLIP:
                begin
                    // undo the half turn taken before the rotation
                    if (flip_reg)
                    begin
                        cx_reg <= -cx_reg;
                        cy_reg <= -cy_reg;
                    end
                    dist_reg  <= mul_reg[DistW-1:0];
                    state_reg <= S_MULX;
                end
                S_MULX:
                begin
                    mul_reg   <= mul_next;
                    state_reg <= S_ADDX;
                end
                S_ADDX:
                begin
                    pos_x_reg <= pos_next;
                    state_reg <= S_MULY;
                end
                S_MULY:
                begin
                    mul_reg   <= mul_next;
                    state_reg <= S_ADDY;
                end
                S_ADDY:
                begin
                    pos_y_reg <= pos_next;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // wait for the output slot before the transfer
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_pos_x_reg   <= pos_x_reg;
                        out_pos_y_reg   <= pos_y_reg;
                        out_heading_reg <= heading_reg;
                        out_rot_reg     <= rot_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block still ready after input transfer");

    a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (AngW'(heading_reg) <= Deg180) && (AngW'(heading_reg) >= DegNeg180))
        else $error("heading outside half-turn range");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ITER |-> iter_reg < IterW'(CordicStages))
        else $error("cordic iteration count overrun");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done step");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && (!out_valid_reg || out_ready) |=> in_ready && out_valid_reg)
        else $error("finished tick not handed to output");

endmodule
`default_nettype wire

FILE: test/tb_differential_drive_odometry_core.sv
module tb_differential_drive_odometry_core;
    import ddo_pkg::*;

    localparam logic [1:0] TurnIgnored = 2'd3;
    localparam longint     TurnStepMax = 127 * 65535;
    localparam int         QuietLimit  = 4000;
    localparam int         LongHold    = 300;

    typedef struct packed {
        logic       sys_on;
        logic       motor_on;
        logic [1:0] turn;
        logic       forward;
        duty_t      duty;
        logic       clear_rot;
    } tick_t;

    typedef struct {
        pos_t     x;
        pos_t     y;
        heading_t hd;
        rot_t     rot;
    } pose_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  cfg_we = 1'b0;
    logic  cfg_index = 1'b0;
    gain_t cfg_data = '0;
    logic  in_valid = 1'b0;
    logic  out_ready = 1'b0;
    tick_t offered = '0;

    logic       in_ready;
    logic       system_on;
    logic       motor_running;
    logic [1:0] turn_direction;
    logic       driving_forward;
    duty_t      duty_percent;
    logic       clear_rotation;
    logic       out_valid;
    pos_t       pos_x;
    pos_t       pos_y;
    heading_t   heading;
    rot_t       rotation_total;

    assign system_on       = offered.sys_on;
    assign motor_running   = offered.motor_on;
    assign turn_direction  = offered.turn;
    assign driving_forward = offered.forward;
    assign duty_percent    = offered.duty;
    assign clear_rotation  = offered.clear_rot;

    differential_drive_odometry_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .system_on       (system_on),
        .motor_running   (motor_running),
        .turn_direction  (turn_direction),
        .driving_forward (driving_forward),
        .duty_percent    (duty_percent),
        .clear_rotation  (clear_rotation),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .heading         (heading),
        .rotation_total  (rotation_total)
    );

    always #2 clk = ~clk;

    // odometry state as the block should hold it
    longint turn_gain_now  = 4194;
    longint drive_gain_now = 5622;
    longint heading_state  = 0;
    longint x_state        = 0;
    longint y_state        = 0;
    longint rot_state      = 0;

    longint arctan_deg [AtanLen] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    tick_t  pending_ticks [$];
    pose_t  expected_poses [$];
    logic   in_took = 1'b0;
    logic   sender_hold = 1'b0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_asked = 0;
    int     mismatches = 0;

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic void cordic_cos_sin(input longint ang, output longint c,
                                           output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        x = longint'(CordicStart);
        y = 0;
        z = ang;
        flip = 1'b0;
        // fold into the right half plane, undo by negating at the end
        if (z > longint'(Deg90))
        begin
            z -= longint'(Deg180);
            flip = 1'b1;
        end
        else if (z < -longint'(Deg90))
        begin
            z += longint'(Deg180);
            flip = 1'b1;
        end
        for (int i = 0; i < CordicStages && i < AtanLen; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_deg[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_deg[i];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic void advance_pose(input tick_t t, output pose_t p);
        longint delta;
        longint travel;
        longint c;
        longint s;
        if (t.clear_rot)
            rot_state = 0;
        if (t.sys_on && t.motor_on)
        begin
            delta = 0;
            if (t.turn == TurnCcw)
                delta = longint'(t.duty) * turn_gain_now;
            else if (t.turn == TurnCw)
                delta = -(longint'(t.duty) * turn_gain_now);
            heading_state += delta;
            rot_state = clamp(rot_state + delta, RotW);
            if (heading_state > longint'(Deg180))
                heading_state -= longint'(Deg360);
            else if (heading_state < -longint'(Deg180))
                heading_state += longint'(Deg360);
            if (t.forward)
            begin
                travel = longint'(t.duty) * drive_gain_now;
                cordic_cos_sin(heading_state, c, s);
                x_state = clamp(x_state + ((travel * c) >>> FracW), PosW);
                y_state = clamp(y_state + ((travel * s) >>> FracW), PosW);
            end
        end
        p.x   = pos_t'(x_state);
        p.y   = pos_t'(y_state);
        p.hd  = heading_t'(heading_state);
        p.rot = rot_t'(rot_state);
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // tick driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending_ticks.size() != 0 && !sender_hold &&
                $urandom_range(99) >= send_idle_pct)
            begin
                offered  <= pending_ticks.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge clk)
    begin : receiver
        int hold_served;
        int hold_left;
        if (rst_n)
        begin
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left = LongHold;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        pose_t want;
        in_took = in_valid && in_ready;
        if (rst_n)
        begin
            // check first so a stray result never pairs with this edge's tick
            if (out_valid && out_ready)
            begin
                if (expected_poses.size() == 0)
                begin
                    $display("%0t: unexpected result x %0d y %0d heading %0d rotation %0d",
                             $time, pos_x, pos_y, heading, rotation_total);
                    mismatches++;
                end
                else
                begin
                    want = expected_poses.pop_front();
                    check_field("pos_x", want.x, pos_x);
                    check_field("pos_y", want.y, pos_y);
                    check_field("heading", want.hd, heading);
                    check_field("rotation_total", want.rot, rotation_total);
                end
            end
            if (in_took)
            begin
                advance_pose(offered, want);
                expected_poses.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else if (quiet >= QuietLimit)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
                quiet++;
        end
    end

    task automatic push_tick(input logic pw, input logic run, input logic [1:0] dir,
                             input logic fwd, input int duty, input logic clr);
        tick_t t;
        t.sys_on    = pw;
        t.motor_on  = run;
        t.turn      = dir;
        t.forward   = fwd;
        t.duty      = duty_t'(duty);
        t.clear_rot = clr;
        pending_ticks.push_back(t);
    endtask

    // runs of ticks that mostly steer one way, so the heading wraps at high gain
    task automatic push_random(input int count);
        logic [1:0] steer;
        int         run_left;
        logic [1:0] dir;
        run_left = 0;
        repeat (count)
        begin
            if (run_left == 0)
            begin
                steer = 2'($urandom_range(3));
                run_left = $urandom_range(40, 15);
            end
            run_left--;
            dir = ($urandom_range(99) < 70) ? steer : 2'($urandom_range(3));
            push_tick($urandom_range(99) < 92, $urandom_range(99) < 90, dir,
                      $urandom_range(99) < 80,
                      ($urandom_range(3) == 0) ? $urandom_range(127, 100) : $urandom_range(127),
                      $urandom_range(99) < 6);
        end
    endtask

    task automatic settle;
        while (pending_ticks.size() != 0 || in_valid || expected_poses.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_gain(input logic idx, input gain_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == RegTurnGain)
            turn_gain_now = value;
        else
            drive_gain_now = value;
    endtask

    task automatic begin_phase(input gain_t tg, input gain_t dg, input int s_idle,
                               input int r_stall);
        settle();
        write_gain(RegTurnGain, tg);
        write_gain(RegDriveGain, dg);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
    endtask

    initial
    begin : stimulus
        longint target;
        longint diff;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed ticks at the reset gains
        push_tick(1, 1, TurnCcw, 1, 100, 0);
        push_tick(0, 1, TurnCcw, 1, 100, 1);     // clear acts while off
        push_tick(1, 0, TurnCw, 1, 127, 0);      // motor stopped
        push_tick(1, 1, TurnCw, 1, 127, 0);      // duty above 100
        push_tick(1, 1, TurnIgnored, 1, 127, 0);
        push_tick(1, 1, TurnCcw, 1, 0, 0);
        push_tick(1, 1, TurnCcw, 0, 127, 0);     // turn in place
        push_tick(1, 1, TurnCw, 1, 50, 1);       // clear before the turn
        push_tick(0, 0, TurnNone, 0, 0, 0);
        push_tick(1, 1, TurnCcw, 1, 127, 1);
        push_tick(1, 1, TurnIgnored, 1, 127, 1);

        // full gain sweep through both wraps, then a long output hold-off
        begin_phase(16'hFFFF, 16'hFFFF, 0, 0);
        repeat (60) push_tick(1, 1, TurnCcw, 1, $urandom_range(127, 100), 0);
        repeat (60) push_tick(1, 1, TurnCw, 1, $urandom_range(127, 100), 0);
        settle();
        hold_asked++;
        push_random(60);

        begin_phase(16'h0000, 16'h0000, 58, 0);
        push_random(80);

        begin_phase(gain_t'($urandom_range(65535)), gain_t'($urandom_range(65535)), 0, 58);
        push_random(100);

        // sender pauses until everything outstanding has come back
        begin_phase(TurnGainReset, DriveGainReset, 23, 23);
        push_random(80);
        while (pending_ticks.size() > 40)
            @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || expected_poses.size() != 0)
            @(posedge clk);
        sender_hold = 1'b0;

        begin_phase(16'hFFFF, 16'h0001, 23, 23);
        push_random(100);

        // long straight run along the x axis at full gain
        begin_phase(16'hFFFF, 16'hFFFF, 0, 0);
        target = (x_state >= 0) ? 0 : longint'(Deg180);
        diff = target - heading_state;
        if (diff > longint'(Deg180))
            diff -= longint'(Deg360);
        else if (diff < -longint'(Deg180))
            diff += longint'(Deg360);
        repeat ((diff < 0 ? -diff : diff) / TurnStepMax)
            push_tick(1, 1, (diff > 0) ? TurnCcw : TurnCw, 0, 127, 0);
        repeat (100) push_tick(1, 1, TurnNone, 1, 127, 0);
        repeat (40) push_tick(1, 1, TurnNone, 1, 127, $urandom_range(1));

        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
